[rtl/ssa_pkg.sv]
// ssa_pkg: shared types, constants and the suitability lookup table for the
// species suitability argmax unit. No dependencies.
package ssa_pkg;

	localparam int NUM_SPECIES = 16;
	localparam int NUM_MAPS    = 4;
	localparam int LUT_DEPTH   = 256;

	localparam int SP_W   = $clog2(NUM_SPECIES);
	localparam int MAP_W  = $clog2(NUM_MAPS);
	localparam int LUT_AW = $clog2(LUT_DEPTH);
	localparam int CNT_W  = (LUT_AW > 1) ? $clog2(LUT_AW) : 1;

	localparam logic [22:0] TOL_FLOOR  = 23'd3;
	localparam logic [63:0] LOG2_5_Q16 = 64'd152170;

	typedef enum logic [1:0] {
		CMD_LOAD_CT = 2'd0,
		CMD_EVAL    = 2'd1,
		CMD_LOAD_MH = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_SETUP,
		S_DIV,
		S_MIN,
		S_FIN
	} state_t;

	typedef logic [15:0] lut_t [LUT_DEPTH];

	function automatic logic [63:0] isqrt64(input logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] xx;
		r  = 64'd0;
		b  = 64'h4000_0000_0000_0000;
		xx = x;
		while (b > xx)
			b = b >> 2;
		while (b != 64'd0) begin
			if (xx >= r + b) begin
				xx = xx - (r + b);
				r  = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [15:0] lut_entry(input int idx);
		logic [63:0]  roots [16];
		logic [63:0]  r;
		logic [63:0]  r2;
		logic [63:0]  r4;
		logic [63:0]  s;
		logic [63:0]  u;
		logic [63:0]  y;
		logic [63:0]  n;
		logic [63:0]  f;
		logic [127:0] v;
		logic [127:0] prod;
		roots[0] = isqrt64(64'h8000_0000_0000_0000);
		for (int j = 1; j < 16; j++)
			roots[j] = isqrt64(roots[j-1] << 32);
		r  = (64'(idx) << 17) / LUT_DEPTH;
		r2 = (r * r) >> 16;
		r4 = (r2 * r2) >> 16;
		s  = isqrt64(r << 16);
		u  = (r4 * s) >> 16;
		y  = (u * LOG2_5_Q16) >> 16;
		n  = y >> 16;
		f  = y & 64'hFFFF;
		v  = 128'd1 << 32;
		if (n >= 64'd17)
			return 16'd0;
		for (int k = 15; k >= 0; k--) begin
			if (f[k]) begin
				prod = v * {64'd0, roots[15-k]};
				v    = {64'd0, prod[95:32]};
			end
		end
		v = v >> (16 + n);
		return (v > 128'd65535) ? 16'hFFFF : v[15:0];
	endfunction

	function automatic lut_t build_lut();
		lut_t t;
		for (int i = 0; i < LUT_DEPTH; i++)
			t[i] = lut_entry(i);
		return t;
	endfunction

	localparam lut_t SUIT_LUT = build_lut();

endpackage

[rtl/species_suitability_argmax_unit.sv]
// species_suitability_argmax_unit: per-pixel species suitability and running argmax.
// Depends on ssa_pkg. A load word is written on its accept; the input stays free.
// An evaluate word stalls the input while it walks the maps (S_READ, S_SETUP,
// S_DIV, S_MIN), the shared bit-serial divider forming each lookup index, one
// quotient bit per cycle; S_FIN posts its result word once the output is free.
// Reset clears control, the output valid flag and the argmax (score 0, species -1).
module species_suitability_argmax_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          cmd,
	input  logic [3:0]          species,
	input  logic [1:0]          map_index,
	input  logic signed [23:0]  param_value,
	input  logic [22:0]         param_tolerance,
	input  logic signed [23:0]  temperature,
	input  logic signed [23:0]  slope,
	input  logic signed [23:0]  moisture,
	input  logic signed [23:0]  sunlight,
	input  logic signed [23:0]  canopy_height,
	input  logic signed [15:0]  multiplier,
	input  logic                last_species,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [3:0]          species_out,
	output logic [15:0]         raw_suitability,
	output logic                skipped,
	output logic                pixel_done,
	output logic signed [4:0]   winner
);
	import ssa_pkg::*;

	// Parameter memories: center/tolerance pairs indexed {species, map},
	// max height indexed by species. Both are read through a register (ct_rd_q, mh_rd_q).
	logic [46:0] ct_mem [NUM_SPECIES*NUM_MAPS];
	logic [23:0] mh_mem [NUM_SPECIES];
	logic [46:0] ct_rd_q;
	logic [23:0] mh_rd_q;

	state_t state_q, state_d;

	// Item held for the duration of one evaluate word.
	logic [SP_W-1:0]    sp_q;
	logic signed [23:0] pix_q [4];
	logic signed [23:0] canopy_q;
	logic signed [15:0] mult_q;
	logic               last_q;

	// Per-map working registers.
	logic [MAP_W-1:0]   map_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [23:0]        rem_q;
	logic [22:0]        tol_q;
	logic               over_q;
	logic [LUT_AW-1:0]  quo_q;
	logic [15:0]        min_q;

	// Running argmax over the species of the current pixel.
	logic [31:0]        best_score_q;
	logic signed [4:0]  best_sp_q;

	// Output register.
	logic               out_valid_q;
	logic [3:0]         species_out_q;
	logic [15:0]        raw_q;
	logic               skipped_q;
	logic               done_q;
	logic signed [4:0]  winner_q;

	logic in_acc;
	logic out_free;
	logic fin_go;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign fin_go   = (state_q == S_FIN) && out_free;

	// Load commands write the memories on the accepting edge.
	always_ff @(posedge clk) begin
		if (in_acc && cmd == CMD_LOAD_CT)
			ct_mem[{species, map_index}] <= {param_value, param_tolerance};
		ct_rd_q <= ct_mem[{sp_q, map_q}];
	end

	always_ff @(posedge clk) begin
		if (in_acc && cmd == CMD_LOAD_MH)
			mh_mem[species] <= param_value;
		mh_rd_q <= mh_mem[sp_q];
	end

	// Distance and floored tolerance for the map just read.
	logic signed [23:0] cen;
	logic [22:0]        tol_raw;
	logic [22:0]        tol_fl;
	logic signed [24:0] diff;
	logic [24:0]        abs_d;
	logic               over;

	assign cen     = ct_rd_q[46:23];
	assign tol_raw = ct_rd_q[22:0];
	assign tol_fl  = (tol_raw < TOL_FLOOR) ? TOL_FLOOR : tol_raw;
	assign diff    = 25'(pix_q[map_q]) - 25'(cen);
	assign abs_d   = diff[24] ? 25'(-diff) : 25'(diff);
	assign over    = {1'b0, abs_d} >= {2'b00, tol_fl, 1'b0};

	// One restoring division step: quotient bit and shifted remainder.
	logic        qbit;
	logic [23:0] rem_sub;

	assign qbit    = rem_q >= {1'b0, tol_q};
	assign rem_sub = qbit ? (rem_q - {1'b0, tol_q}) : rem_q;

	// Lookup and score for the closing stage.
	logic [15:0]       lut_val;
	logic              skip_now;
	logic [15:0]       raw_now;
	logic [14:0]       mult_cl;
	logic [31:0]       score;
	logic              better;
	logic signed [4:0] best_sp_new;

	assign lut_val     = over_q ? 16'd0 : SUIT_LUT[quo_q];
	assign skip_now    = canopy_q > $signed(mh_rd_q);
	assign raw_now     = skip_now ? 16'd0 : min_q;
	assign mult_cl     = mult_q[15] ? 15'd0 : mult_q[14:0];
	assign score       = 32'(raw_now) * 32'(mult_cl);
	assign better      = !skip_now && (score > best_score_q);
	assign best_sp_new = better ? $signed({1'b0, sp_q}) : best_sp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc && cmd == CMD_EVAL)
					state_d = S_READ;
			end
			S_READ:  state_d = S_SETUP;
			S_SETUP: state_d = S_DIV;
			S_DIV: begin
				if (cnt_q == CNT_W'(LUT_AW - 1))
					state_d = S_MIN;
			end
			S_MIN: begin
				if (map_q == MAP_W'(NUM_MAPS - 1))
					state_d = S_FIN;
				else
					state_d = S_READ;
			end
			S_FIN: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Datapath: capture the item, walk the maps, fold the minimum.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sp_q     <= species;
			pix_q[0] <= temperature;
			pix_q[1] <= slope;
			pix_q[2] <= moisture;
			pix_q[3] <= sunlight;
			canopy_q <= canopy_height;
			mult_q   <= multiplier;
			last_q   <= last_species;
			min_q    <= 16'hFFFF;
			map_q    <= '0;
		end
		if (state_q == S_SETUP) begin
			tol_q  <= tol_fl;
			over_q <= over;
			rem_q  <= abs_d[23:0];
			cnt_q  <= '0;
		end
		if (state_q == S_DIV) begin
			quo_q <= {quo_q[LUT_AW-2:0], qbit};
			rem_q <= {rem_sub[22:0], 1'b0};
			cnt_q <= cnt_q + 1'b1;
		end
		if (state_q == S_MIN) begin
			if (lut_val < min_q)
				min_q <= lut_val;
			map_q <= map_q + 1'b1;
		end
	end

	// Argmax update and result word; clear the argmax when the pixel closes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_score_q <= '0;
			best_sp_q    <= -5'sd1;
			out_valid_q  <= 1'b0;
		end else begin
			if (fin_go) begin
				out_valid_q <= 1'b1;
				if (last_q) begin
					best_score_q <= '0;
					best_sp_q    <= -5'sd1;
				end else if (better) begin
					best_score_q <= score;
					best_sp_q    <= best_sp_new;
				end
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			species_out_q <= 4'(sp_q);
			raw_q         <= raw_now;
			skipped_q     <= skip_now;
			done_q        <= last_q;
			winner_q      <= last_q ? best_sp_new : 5'sd0;
		end
	end

	assign out_valid       = out_valid_q;
	assign species_out     = species_out_q;
	assign raw_suitability = raw_q;
	assign skipped         = skipped_q;
	assign pixel_done      = done_q;
	assign winner          = winner_q;

`ifndef SYNTH
	a_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go && last_q |=> best_score_q == 32'd0 && best_sp_q == -5'sd1)
		else $error("argmax not cleared after pixel close");

	a_skip_raw_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && skipped_q |-> raw_q == 16'd0)
		else $error("skipped result carries nonzero suitability");

	a_idle_map_zero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ && $past(state_q) == S_IDLE |-> map_q == '0)
		else $error("map walk did not start at map zero");

	a_fin_only_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN && out_valid_q && out_stall |=> state_q == S_FIN)
		else $error("result dropped while output stalled");
`endif

endmodule

[tb/species_suitability_checker.sv]
// species_suitability_checker: watches both channels of the species suitability
// argmax unit, predicts each result word and compares it. Depends on ssa_pkg.
module species_suitability_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [1:0]         cmd,
	input  logic [3:0]         species,
	input  logic [1:0]         map_index,
	input  logic signed [23:0] param_value,
	input  logic [22:0]        param_tolerance,
	input  logic signed [23:0] temperature,
	input  logic signed [23:0] slope,
	input  logic signed [23:0] moisture,
	input  logic signed [23:0] sunlight,
	input  logic signed [23:0] canopy_height,
	input  logic signed [15:0] multiplier,
	input  logic               last_species,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [3:0]         species_out,
	input  logic [15:0]        raw_suitability,
	input  logic               skipped,
	input  logic               pixel_done,
	input  logic signed [4:0]  winner,
	output int                 fails,
	output int                 pending
);
	import ssa_pkg::*;

	typedef struct packed {
		logic [3:0]        sp;
		logic [15:0]       raw;
		logic              skip;
		logic              done;
		logic signed [4:0] win;
	} verdict_t;

	verdict_t          verdict_q[$];
	logic [15:0]       curve[LUT_DEPTH];
	logic [63:0]       ladder[16];
	logic signed [23:0] centers[NUM_SPECIES*NUM_MAPS];
	logic [22:0]       tols[NUM_SPECIES*NUM_MAPS];
	logic signed [23:0] heights[NUM_SPECIES];
	logic [31:0]       lead_score;
	logic signed [4:0] lead_species;

	function automatic logic [63:0] floor_sqrt(logic [63:0] x);
		logic [63:0] acc;
		logic [63:0] bit_v;
		acc = 0;
		bit_v = 64'h4000_0000_0000_0000;
		while (bit_v > x)
			bit_v >>= 2;
		while (bit_v != 0) begin
			if (x >= acc + bit_v) begin
				x -= acc + bit_v;
				acc = (acc >> 1) + bit_v;
			end else begin
				acc >>= 1;
			end
			bit_v >>= 2;
		end
		return acc;
	endfunction

	// 0.2^(r^4.5) as 2^-(r^4.5 * log2 5), with the fraction built from a root ladder
	function automatic logic [15:0] decay_at(int idx);
		logic [63:0]  r, r2, r4, s, u, y, n, f;
		logic [127:0] acc;
		r  = (64'(idx) << 17) / LUT_DEPTH;
		r2 = (r * r) >> 16;
		r4 = (r2 * r2) >> 16;
		s  = floor_sqrt(r << 16);
		u  = (r4 * s) >> 16;
		y  = (u * 64'd152170) >> 16;
		n  = y >> 16;
		f  = y & 64'hFFFF;
		if (n >= 17)
			return 16'd0;
		acc = 128'd1 << 32;
		for (int k = 15; k >= 0; k--)
			if (f[k])
				acc = (acc * ladder[15-k]) >> 32;
		acc >>= (16 + n);
		return (acc > 65535) ? 16'hFFFF : acc[15:0];
	endfunction

	initial begin
		ladder[0] = floor_sqrt(64'h8000_0000_0000_0000);
		for (int j = 1; j < 16; j++)
			ladder[j] = floor_sqrt(ladder[j-1] << 32);
		for (int i = 0; i < LUT_DEPTH; i++)
			curve[i] = decay_at(i);
	end

	function automatic verdict_t evaluate_word();
		verdict_t   v;
		logic signed [23:0] px[4];
		longint     diff;
		logic [63:0] d, t, idx;
		logic [15:0] e, low;
		logic [31:0] weight, score;
		px[0] = temperature; px[1] = slope; px[2] = moisture; px[3] = sunlight;
		v = '0;
		v.sp = species;
		if (canopy_height > heights[species]) begin
			v.skip = 1;
		end else begin
			low = 16'hFFFF;
			for (int m = 0; m < NUM_MAPS; m++) begin
				diff = longint'(px[m % 4]) - longint'(centers[species*NUM_MAPS+m]);
				d = (diff < 0) ? -diff : diff;
				t = tols[species*NUM_MAPS+m];
				if (t < 3)
					t = 3;
				idx = (d * LUT_DEPTH) / (2 * t);
				e = (idx >= LUT_DEPTH) ? 16'd0 : curve[idx];
				if (e < low)
					low = e;
			end
			v.raw = low;
			weight = multiplier[15] ? 32'd0 : 32'(multiplier);
			score = 32'(low) * weight;
			if (score > lead_score) begin
				lead_score = score;
				lead_species = 5'(species);
			end
		end
		if (last_species) begin
			v.done = 1;
			v.win = lead_species;
			lead_score = 0;
			lead_species = -1;
		end
		return v;
	endfunction

	assign pending = verdict_q.size();

	always @(posedge clk or negedge arst_n) begin
		verdict_t got, want;
		if (!arst_n) begin
			fails = 0;
			lead_score = 0;
			lead_species = -1;
			verdict_q.delete();
		end else begin
			if (in_valid && !in_stall) begin
				case (cmd)
					CMD_LOAD_CT: begin
						centers[species*NUM_MAPS+map_index] = param_value;
						tols[species*NUM_MAPS+map_index] = param_tolerance;
					end
					CMD_LOAD_MH: heights[species] = param_value;
					CMD_EVAL:    verdict_q = {verdict_q, evaluate_word()};
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				got = '{species_out, raw_suitability, skipped, pixel_done, winner};
				if (verdict_q.size() == 0) begin
					fails++;
					$display("%0t: result word with none expected: %p", $time, got);
				end else begin
					want = verdict_q.pop_front();
					if (got.sp !== want.sp) begin
						fails++;
						$display("%0t: species_out exp %0d got %0d", $time, want.sp, got.sp);
					end
					if (got.raw !== want.raw) begin
						fails++;
						$display("%0t: raw_suitability exp %0d got %0d", $time, want.raw,
							got.raw);
					end
					if (got.skip !== want.skip) begin
						fails++;
						$display("%0t: skipped exp %0d got %0d", $time, want.skip, got.skip);
					end
					if (got.done !== want.done) begin
						fails++;
						$display("%0t: pixel_done exp %0d got %0d", $time, want.done,
							got.done);
					end
					if (got.win !== want.win) begin
						fails++;
						$display("%0t: winner exp %0d got %0d", $time, want.win, got.win);
					end
				end
			end
		end
	end

endmodule

[tb/tb_species_suitability_argmax_unit.sv]
// tb_species_suitability_argmax_unit: stimulus and verdict for the species
// suitability argmax unit. Depends on ssa_pkg, the unit and species_suitability_checker.
module tb_species_suitability_argmax_unit;
	import ssa_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         cmd;
	logic [3:0]         species;
	logic [1:0]         map_index;
	logic signed [23:0] param_value;
	logic [22:0]        param_tolerance;
	logic signed [23:0] temperature;
	logic signed [23:0] slope;
	logic signed [23:0] moisture;
	logic signed [23:0] sunlight;
	logic signed [23:0] canopy_height;
	logic signed [15:0] multiplier;
	logic               last_species;
	logic               out_valid;
	logic               out_stall;
	logic [3:0]         species_out;
	logic [15:0]        raw_suitability;
	logic               skipped;
	logic               pixel_done;
	logic signed [4:0]  winner;
	int                 fails;
	int                 pending;

	// Shadow of what was loaded: steers pixel values near each center so
	// lookups land inside the curve instead of always reading zero.
	int  center_sh[NUM_SPECIES][NUM_MAPS];
	int  tol_sh[NUM_SPECIES][NUM_MAPS];
	int  height_sh[NUM_SPECIES];
	// Hold gaps off on both sides while calm is set.
	bit  calm;
	int  out_hold;

	species_suitability_argmax_unit i_dut (.*);

	species_suitability_checker i_check (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Receiver: draw a stall length after each accepted word, count it down.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_hold = 0;
		end else if (out_valid && !out_stall) begin
			out_hold = calm ? 0 : $urandom_range(0, 3);
			out_stall <= (out_hold != 0);
		end else if (out_hold > 0) begin
			out_hold--;
			out_stall <= (out_hold != 0);
		end
	end

	// Offer one word; gap first, then hold valid and payload until accepted.
	task automatic send_word(cmd_t c, int sp, int mi, int pv, int tol,
		int px[4], int canopy, int mult, bit last);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid        <= 1'b1;
		cmd             <= c;
		species         <= sp[3:0];
		map_index       <= mi[1:0];
		param_value     <= pv[23:0];
		param_tolerance <= tol[22:0];
		temperature     <= px[0][23:0];
		slope           <= px[1][23:0];
		moisture        <= px[2][23:0];
		sunlight        <= px[3][23:0];
		canopy_height   <= canopy[23:0];
		multiplier      <= mult[15:0];
		last_species    <= last;
		do @(posedge clk); while (in_stall);
	endtask

	function automatic int any24();
		return int'($signed($urandom_range(0, 24'hFFFFFF) << 8)) >>> 8;
	endfunction

	task automatic load_center(int sp, int mi, int c, int tol);
		int none[4] = '{0, 0, 0, 0};
		center_sh[sp][mi] = c;
		tol_sh[sp][mi] = tol;
		send_word(CMD_LOAD_CT, sp, mi, c, tol, none, 0, 0, 0);
	endtask

	task automatic load_height(int sp, int h);
		int none[4] = '{0, 0, 0, 0};
		height_sh[sp] = h;
		send_word(CMD_LOAD_MH, sp, 0, h, 0, none, 0, 0, 0);
	endtask

	// Evaluate with each map value within a few tolerances of its center.
	task automatic eval_near(int sp, int mult, bit last);
		int px[4];
		int span;
		int canopy;
		for (int m = 0; m < 4; m++) begin
			span = (tol_sh[sp][m] < 3 ? 3 : tol_sh[sp][m]) * 3;
			px[m] = center_sh[sp][m] + $urandom_range(0, 2 * span) - span;
			if (px[m] > 8388607) px[m] = 8388607;
			if (px[m] < -8388608) px[m] = -8388608;
		end
		canopy = ($urandom_range(0, 7) == 0) ? height_sh[sp] + $urandom_range(1, 500)
			: height_sh[sp] - $urandom_range(0, 2000);
		if (canopy > 8388607) canopy = 8388607;
		if (canopy < -8388608) canopy = -8388608;
		send_word(CMD_EVAL, sp, $urandom_range(0, 3), any24(), $urandom_range(0, 23'h7FFFFF),
			px, canopy, mult, last);
	endtask

	function automatic int rand_mult();
		case ($urandom_range(0, 5))
			0: return -int'($urandom_range(1, 32768));
			1: return int'($signed($urandom_range(0, 16'hFFFF) << 16)) >>> 16;
			default: return $urandom_range(1, 1024);
		endcase
	endfunction

	initial begin
		int px[4];
		int n_sp;
		arst_n = 1'b0;
		calm = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_NONE;
		species = '0;
		map_index = '0;
		param_value = '0;
		param_tolerance = '0;
		temperature = '0;
		slope = '0;
		moisture = '0;
		sunlight = '0;
		canopy_height = '0;
		multiplier = '0;
		last_species = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill the whole table before any evaluate reads it.
		for (int s = 0; s < NUM_SPECIES; s++) begin
			for (int m = 0; m < NUM_MAPS; m++)
				load_center(s, m, $urandom_range(0, 4000) - 2000, $urandom_range(0, 600));
			load_height(s, $urandom_range(0, 8000));
		end
		// Extremes in the table: floor-level and maximum tolerance, extreme centers.
		load_center(0, 0, 0, 0);
		load_center(0, 1, 0, 23'h7FFFFF);
		load_center(1, 0, -8388608, 100);
		load_center(1, 1, 8388607, 100);
		load_height(2, -8388608);
		load_height(3, 8388607);

		// Directed: exact centers (full suitability), far values, clamped weights.
		for (int m = 0; m < 4; m++) px[m] = center_sh[0][m];
		send_word(CMD_EVAL, 0, 0, 0, 0, px, -8388608, 32767, 0);
		send_word(CMD_EVAL, 0, 0, 0, 0, px, 0, -32768, 0);
		send_word(CMD_EVAL, 0, 0, 0, 0, px, 0, 0, 1);
		px = '{-8388608, -8388608, -8388608, -8388608};
		send_word(CMD_EVAL, 1, 3, 0, 0, px, -8388608, 256, 0);
		px = '{8388607, 8388607, 8388607, 8388607};
		send_word(CMD_EVAL, 1, 3, 0, 0, px, -8388608, 256, 1);
		// Skipped: canopy above a minimum max height; no positive score gives -1.
		send_word(CMD_EVAL, 2, 0, 0, 0, px, 0, 100, 1);
		eval_near(3, 100, 0);
		eval_near(4, 100, 0);
		eval_near(3, 100, 1);
		// Ignored command: no result expected.
		send_word(CMD_NONE, 15, 3, -1, 23'h7FFFFF, px, 0, 0, 1);
		eval_near(15, 32767, 1);

		// Hold off until the unit drains, then a calm stretch.
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		calm = 1'b1;
		for (int k = 0; k < 20; k++)
			eval_near($urandom_range(0, 15), rand_mult(), $urandom_range(0, 1));
		calm = 1'b0;

		// Random pixels of a few species each, with occasional reloads and noise.
		for (int k = 0; k < 630; ) begin
			case ($urandom_range(0, 9))
				0: begin
					load_center($urandom_range(0, 15), $urandom_range(0, 3),
						($urandom_range(0, 9) == 0) ? any24() : $urandom_range(0, 4000) - 2000,
						($urandom_range(0, 9) == 0) ? $urandom_range(0, 23'h7FFFFF)
							: $urandom_range(0, 600));
					k++;
				end
				1: begin
					load_height($urandom_range(0, 15),
						($urandom_range(0, 5) == 0) ? any24() : $urandom_range(0, 8000));
					k++;
				end
				2: begin
					for (int m = 0; m < 4; m++) px[m] = any24();
					send_word(CMD_EVAL, $urandom_range(0, 15), 0, 0, 0, px, any24(),
						rand_mult(), $urandom_range(0, 1));
					k++;
				end
				3: begin
					if ($urandom_range(0, 3) == 0)
						send_word(CMD_NONE, $urandom_range(0, 15), $urandom_range(0, 3),
							any24(), $urandom_range(0, 23'h7FFFFF), px, any24(), rand_mult(), 1);
				end
				default: begin
					n_sp = $urandom_range(1, 5);
					for (int j = 0; j < n_sp; j++)
						eval_near($urandom_range(0, 15), rand_mult(), j == n_sp - 1);
					k += n_sp;
				end
			endcase
		end
		in_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (fails == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Slowest run is about 750 words; allow several times that before giving up.
	initial begin
		#3000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

[species_suitability_argmax_unit.f]
rtl/ssa_pkg.sv
rtl/species_suitability_argmax_unit.sv
tb/species_suitability_checker.sv
tb/tb_species_suitability_argmax_unit.sv
